// ----- hw/rtl/bccm_pkg.sv -----
// Shared constants, widths and handshake types of the bounded composition counter.
package bccm_pkg;

	localparam int unsigned TABLE_SIZE_DEF = 262144;

	localparam int NW = 18;
	localparam int KW = 17;
	localparam int VW = 30;

	localparam logic [VW-1:0] PRIME   = 30'd998244353;
	localparam logic [VW-1:0] INV_EXP = 30'd998244351;

	localparam logic [VW:0] BARRETT_MU = (VW+1)'((64'd1 << (2*VW)) / 64'(PRIME));

	typedef struct packed {
		logic          start;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic          done;
		logic [VW-1:0] res;
	} mm_rsp_t;

endpackage

// ----- hw/rtl/bccm_query_if.sv -----
// Query channel: part bound, part count and total with valid/ready handshake.
interface bccm_query_if import bccm_pkg::*;;
	logic          valid;
	logic          ready;
	logic [NW-1:0] part_bound;
	logic [NW-1:0] part_count;
	logic [KW-1:0] total;

	modport source (output valid, output part_bound, output part_count, output total,
		input ready);
	modport sink (input valid, input part_bound, input part_count, input total,
		output ready);
endinterface

// ----- hw/rtl/bccm_result_if.sv -----
// Result channel: composition count modulo the prime with valid/ready handshake.
interface bccm_result_if import bccm_pkg::*;;
	logic          valid;
	logic          ready;
	logic [VW-1:0] count_mod_p;

	modport source (output valid, output count_mod_p, input ready);
	modport sink (input valid, input count_mod_p, output ready);
endinterface

// ----- hw/rtl/bccm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bccm_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/bccm_modmul.sv -----
// Five-stage modular multiplier with Barrett reduction by the fixed prime.
module bccm_modmul import bccm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);
	localparam logic [31:0] P1 = 32'(PRIME);
	localparam logic [31:0] P2 = 32'(PRIME) << 1;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2*VW-1:0]     prod_s1;
	logic [2*VW+1:0]     q2_s2;
	logic [31:0]         lo_s2, lo_s3, qp_s3, r_s4;
	logic [VW-1:0]       res_s5;
	logic [31:0]         r_red;

	always_comb begin
		if (r_s4 >= P2) begin
			r_red = r_s4 - P2;
		end else if (r_s4 >= P1) begin
			r_red = r_s4 - P1;
		end else begin
			r_red = r_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (2*VW)'(req.a) * (2*VW)'(req.b);
		q2_s2   <= (2*VW+2)'(prod_s1[2*VW-1:VW-1]) * (2*VW+2)'(BARRETT_MU);
		lo_s2   <= prod_s1[31:0];
		qp_s3   <= 32'(q2_s2[2*VW+1:VW+1]) * P1;
		lo_s3   <= lo_s2;
		r_s4    <= lo_s3 - qp_s3;
		res_s5  <= VW'(r_red);
	end

	assign rsp.done = v_s5;
	assign rsp.res  = res_s5;
endmodule

// ----- hw/rtl/bccm_seq.sv -----
// Sequencer: table build after reset and inclusion-exclusion loop per query.
module bccm_seq import bccm_pkg::*; #(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bccm_query_if.sink           query,
	bccm_result_if.source        result,
	output logic                 fact_we,
	output logic [AW-1:0]        fact_raddr,
	input  logic [VW-1:0]        fact_rdata,
	output logic                 inv_we,
	output logic [AW-1:0]        inv_raddr,
	input  logic [VW-1:0]        inv_rdata,
	output logic [AW-1:0]        waddr,
	output logic [VW-1:0]        wdata,
	output mm_req_t              mm_req,
	input  mm_rsp_t              mm_rsp
);
	typedef enum logic [27:0] {
		S_FACT_WR  = 28'h0000001,
		S_FACT_MUL = 28'h0000002,
		S_FACT_WAIT= 28'h0000004,
		S_EXP_SQ   = 28'h0000008,
		S_EXP_SQW  = 28'h0000010,
		S_EXP_XM   = 28'h0000020,
		S_EXP_XMW  = 28'h0000040,
		S_INV_WR   = 28'h0000080,
		S_INV_MUL  = 28'h0000100,
		S_INV_WAIT = 28'h0000200,
		S_IDLE     = 28'h0000400,
		S_PRO_RD   = 28'h0000800,
		S_PRO_CAP  = 28'h0001000,
		S_T_RD     = 28'h0002000,
		S_T_M1     = 28'h0004000,
		S_T_RDI    = 28'h0008000,
		S_T_RDM    = 28'h0010000,
		S_T_W1     = 28'h0020000,
		S_T_M2     = 28'h0040000,
		S_T_W2     = 28'h0080000,
		S_T_M3     = 28'h0100000,
		S_T_W3     = 28'h0200000,
		S_T_M4     = 28'h0400000,
		S_T_W4     = 28'h0800000,
		S_T_M5     = 28'h1000000,
		S_T_W5     = 28'h2000000,
		S_T_ACC    = 28'h4000000,
		S_FIN      = 28'h8000000
	} state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

	state_t          state_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   idx_nx;
	logic [4:0]      ebit_q;
	logic [VW-1:0]   val_q, x_q, fm_q, ivm1_q, ta_q, tb_q, tc_q, acc_q, out_q;
	logic            out_v_q;
	logic [NW-1:0]   n_q, m_q, i_q;
	logic [KW-1:0]   rest_q;
	logic [NW+1:0]   t1;
	logic            tok;
	logic            m_fits;
	logic            more;
	logic            load_out;
	logic [VW:0]     sum;
	logic [VW-1:0]   acc_add, acc_sub;

	assign idx_nx = idx_q + 1'b1;
	assign t1     = (NW+2)'(rest_q) + (NW+2)'(m_q) - (NW+2)'(1);
	assign tok    = 32'(t1) < 32'(TABLE_SIZE);
	assign m_fits = 32'(query.part_count) < 32'(TABLE_SIZE);
	assign more   = (i_q < m_q) && (NW'(rest_q) >= n_q);

	assign load_out = (state_q == S_FIN) && (!out_v_q || result.ready);

	assign sum     = {1'b0, acc_q} + {1'b0, val_q};
	assign acc_add = (sum >= {1'b0, PRIME}) ? VW'(sum - {1'b0, PRIME}) : VW'(sum);
	assign acc_sub = (acc_q >= val_q) ? acc_q - val_q : acc_q + (PRIME - val_q);

	assign query.ready        = (state_q == S_IDLE);
	assign result.valid       = out_v_q;
	assign result.count_mod_p = out_q;

	assign waddr = idx_q;
	assign wdata = val_q;

	always_comb begin
		fact_we    = 1'b0;
		inv_we     = 1'b0;
		fact_raddr = '0;
		inv_raddr  = '0;
		mm_req     = '{start: 1'b0, a: val_q, b: val_q};
		unique case (state_q)
			S_FACT_WR:  fact_we = 1'b1;
			S_FACT_MUL: mm_req = '{start: 1'b1, a: val_q, b: VW'(idx_nx)};
			S_EXP_SQ:   mm_req = '{start: 1'b1, a: val_q, b: val_q};
			S_EXP_XM:   mm_req = '{start: 1'b1, a: val_q, b: x_q};
			S_INV_WR:   inv_we = 1'b1;
			S_INV_MUL:  mm_req = '{start: 1'b1, a: val_q, b: VW'(idx_q)};
			S_PRO_RD: begin
				fact_raddr = AW'(m_q);
				inv_raddr  = AW'(m_q - NW'(1));
			end
			S_T_RD: begin
				fact_raddr = AW'(t1);
				inv_raddr  = AW'(rest_q);
			end
			S_T_M1: begin
				mm_req    = '{start: 1'b1, a: fact_rdata, b: ivm1_q};
				inv_raddr = AW'(i_q);
			end
			S_T_RDI:    inv_raddr = AW'(m_q - i_q);
			S_T_M2:     mm_req = '{start: 1'b1, a: val_q, b: ta_q};
			S_T_M3:     mm_req = '{start: 1'b1, a: fm_q, b: tb_q};
			S_T_M4:     mm_req = '{start: 1'b1, a: tb_q, b: tc_q};
			S_T_M5:     mm_req = '{start: 1'b1, a: val_q, b: tb_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FACT_WR;
			idx_q   <= '0;
			val_q   <= VW'(1);
			ebit_q  <= 5'(VW - 1);
			out_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q) inside
				S_FACT_WR: begin
					if (idx_q == LAST_IDX) begin
						x_q     <= val_q;
						val_q   <= VW'(1);
						ebit_q  <= 5'(VW - 1);
						state_q <= S_EXP_SQ;
					end else begin
						state_q <= S_FACT_MUL;
					end
				end
				S_FACT_MUL: state_q <= S_FACT_WAIT;
				S_FACT_WAIT: begin
					if (mm_rsp.done) begin
						val_q   <= mm_rsp.res;
						idx_q   <= idx_nx;
						state_q <= S_FACT_WR;
					end
				end
				S_EXP_SQ: state_q <= S_EXP_SQW;
				S_EXP_SQW, S_EXP_XMW: begin
					if (mm_rsp.done) begin
						val_q <= mm_rsp.res;
						if (state_q == S_EXP_SQW && INV_EXP[ebit_q]) begin
							state_q <= S_EXP_XM;
						end else if (ebit_q == '0) begin
							idx_q   <= LAST_IDX;
							state_q <= S_INV_WR;
						end else begin
							ebit_q  <= ebit_q - 1'b1;
							state_q <= S_EXP_SQ;
						end
					end
				end
				S_EXP_XM: state_q <= S_EXP_XMW;
				S_INV_WR: begin
					state_q <= (idx_q == '0) ? S_IDLE : S_INV_MUL;
				end
				S_INV_MUL: state_q <= S_INV_WAIT;
				S_INV_WAIT: begin
					if (mm_rsp.done) begin
						val_q   <= mm_rsp.res;
						idx_q   <= idx_q - 1'b1;
						state_q <= S_INV_WR;
					end
				end
				S_IDLE: begin
					if (query.valid) begin
						n_q    <= query.part_bound;
						m_q    <= query.part_count;
						rest_q <= query.total;
						i_q    <= '0;
						if (query.part_count == '0) begin
							acc_q   <= (query.total == '0) ? VW'(1) : '0;
							state_q <= S_FIN;
						end else if (query.part_bound == '0 || !m_fits) begin
							acc_q   <= '0;
							state_q <= S_FIN;
						end else begin
							acc_q   <= '0;
							state_q <= S_PRO_RD;
						end
					end
				end
				S_PRO_RD: state_q <= S_PRO_CAP;
				S_PRO_CAP: begin
					fm_q    <= fact_rdata;
					ivm1_q  <= inv_rdata;
					state_q <= S_T_RD;
				end
				S_T_RD: begin
					if (tok) begin
						state_q <= S_T_M1;
					end else begin
						val_q   <= '0;
						state_q <= S_T_ACC;
					end
				end
				S_T_M1: begin
					ta_q    <= inv_rdata;
					state_q <= S_T_RDI;
				end
				S_T_RDI: begin
					tb_q    <= inv_rdata;
					state_q <= S_T_RDM;
				end
				S_T_RDM: begin
					tc_q    <= inv_rdata;
					state_q <= S_T_W1;
				end
				S_T_W1: begin
					if (mm_rsp.done) begin
						val_q   <= mm_rsp.res;
						state_q <= S_T_M2;
					end
				end
				S_T_M2: state_q <= S_T_W2;
				S_T_W2: begin
					if (mm_rsp.done) begin
						val_q   <= mm_rsp.res;
						state_q <= S_T_M3;
					end
				end
				S_T_M3: state_q <= S_T_W3;
				S_T_W3: begin
					if (mm_rsp.done) begin
						tb_q    <= mm_rsp.res;
						state_q <= S_T_M4;
					end
				end
				S_T_M4: state_q <= S_T_W4;
				S_T_W4: begin
					if (mm_rsp.done) begin
						tb_q    <= mm_rsp.res;
						state_q <= S_T_M5;
					end
				end
				S_T_M5: state_q <= S_T_W5;
				S_T_W5: begin
					if (mm_rsp.done) begin
						val_q   <= mm_rsp.res;
						state_q <= S_T_ACC;
					end
				end
				S_T_ACC: begin
					acc_q <= i_q[0] ? acc_sub : acc_add;
					if (more) begin
						rest_q  <= rest_q - KW'(n_q);
						i_q     <= i_q + 1'b1;
						state_q <= S_T_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						out_q   <= acc_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/bounded_composition_count_mod_p.sv -----
// Top level of the bounded composition counter modulo 998244353.
//
// Query channel (valid/ready) carries part_bound n, part_count m and total k; the
// result channel returns one count_mod_p per query: the number of ordered m-tuples
// with parts in 0..n-1 summing to k. A query transaction is taken only while the
// sequencer is idle, one at a time.
// After arst_n releases, the block builds its factorial and inverse-factorial
// tables in two RAMs before it raises ready, with one modular multiply per
// entry on each walk, plus a 58-step exponentiation for the top inverse.
// A trivial query (m = 0, n = 0, or m beyond the table) skips the term loop;
// otherwise the loop runs min(m, k/n) + 1 terms. Each term needs four table
// reads on the single RAM read ports and five dependent multiplies through the one
// shared five-stage modular multiplier, which sets the rate.
// The result waits in an output register: while the receiver stalls, the next
// query transaction is still taken and computed, and its result is held back until
// the previous one has gone.
module bounded_composition_count_mod_p import bccm_pkg::*; #(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bccm_query_if.sink    query,
	bccm_result_if.source result
);
	localparam int AW = $clog2(TABLE_SIZE);

	logic            fact_we, inv_we;
	logic [AW-1:0]   fact_raddr, inv_raddr, waddr;
	logic [VW-1:0]   fact_rdata, inv_rdata, wdata;
	mm_req_t         mm_req;
	mm_rsp_t         mm_rsp;

	bccm_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_fact_ram (
		.clk   (clk),
		.we    (fact_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (fact_raddr),
		.rdata (fact_rdata)
	);

	bccm_ram #(.WIDTH(VW), .DEPTH(TABLE_SIZE)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (inv_raddr),
		.rdata (inv_rdata)
	);

	bccm_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	bccm_seq #(.TABLE_SIZE(TABLE_SIZE)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.query      (query),
		.result     (result),
		.fact_we    (fact_we),
		.fact_raddr (fact_raddr),
		.fact_rdata (fact_rdata),
		.inv_we     (inv_we),
		.inv_raddr  (inv_raddr),
		.inv_rdata  (inv_rdata),
		.waddr      (waddr),
		.wdata      (wdata),
		.mm_req     (mm_req),
		.mm_rsp     (mm_rsp)
	);
endmodule

// ----- hw/rtl/bccm_chk.sv -----
// Port-level checker of the bounded composition counter and its bind.
module bccm_chk import bccm_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          q_valid,
	input logic          q_ready,
	input logic          r_valid,
	input logic          r_ready,
	input logic [VW-1:0] r_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_count))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_count < PRIME)
		else $error("result not reduced modulo the prime");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> !q_ready)
		else $error("query taken while a previous one is in work");

	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> !$past(q_ready))
		else $error("result appeared from the idle state");
endmodule

bind bounded_composition_count_mod_p bccm_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.q_valid (query.valid),
	.q_ready (query.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_count (result.count_mod_p)
);
